// File: hdl/ssfs_pkg.sv
package ssfs_pkg;

  localparam int unsigned MAX_GRID   = 256;
  localparam int unsigned GRID_W     = 9;
  localparam int unsigned IDX_W      = 8;
  localparam int unsigned EL_W       = 32;
  localparam int unsigned DELTA_W    = 16;
  localparam int unsigned DIG_W      = 4;
  localparam int unsigned ACC_STEPS  = EL_W / DIG_W;
  localparam int unsigned UV_W       = 16;
  localparam int unsigned DIV_STEPS  = UV_W;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    FN_TICK   = 3'd0,
    FN_PLAY   = 3'd1,
    FN_PAUSE  = 3'd2,
    FN_RESUME = 3'd3,
    FN_INIT   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    MODE_LOOP      = 2'd0,
    MODE_LOOP_HOLD = 2'd1,
    MODE_ONCE      = 2'd2,
    MODE_ONCE_HOLD = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMN_COUNT    = 3'd0,
    CFG_ROW_COUNT       = 3'd1,
    CFG_ROW_SELECT      = 3'd2,
    CFG_FIRST_COLUMN    = 3'd3,
    CFG_LAST_COLUMN_SEL = 3'd4,
    CFG_FRAME_DELAY     = 3'd5,
    CFG_PLAY_MODE       = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_UPD,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [GRID_W-1:0]        column_count;
    logic [GRID_W-1:0]        row_count;
    logic [IDX_W-1:0]         row_select;
    logic [IDX_W-1:0]         first_column;
    logic signed [GRID_W-1:0] last_column_sel;
    logic [EL_W-1:0]          frame_delay;
    logic [1:0]               play_mode;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [DELTA_W-1:0] time_delta;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] frame_index;
    logic [IDX_W-1:0] column_index;
    logic [IDX_W-1:0] row_index;
    logic [UV_W-1:0]  center_u;
    logic [UV_W-1:0]  center_v;
    logic [UV_W-1:0]  half_u;
    logic [UV_W-1:0]  half_v;
    logic             is_paused;
    logic             reached_end;
  } out_item_t;

  typedef struct packed {
    logic [GRID_W-1:0] cols;
    logic [GRID_W-1:0] rows;
    logic [IDX_W-1:0]  span;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
  } geom_t;

  typedef struct packed {
    logic load;
    logic step;
    logic clear;
  } acc_ctrl_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctrl_t;

endpackage

// File: hdl/ssfs_chan_if.sv
interface ssfs_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/sprite_sheet_frame_sequencer_core.sv
// Channel | Dir | Payload     | Transaction
// req_i   | in  | in_item_t   | one command or tick
// rsp_o   | out | out_item_t  | one result per request
// cfg_*   | in  | idx, data   | register write, no handshake
//
// Unpaused tick: after accept the elapsed time is added and compared in 4-bit
// serial steps, the frame is updated, and the four UV lanes are loaded and run 16
// restoring divider steps in parallel before the result register loads in done.
// Other requests go straight to done. A new request is taken only when idle.
// Reset: paused, frame 0, elapsed 0, held UV 0, registers at defaults.
// A stalled result holds in the output register; the next request is taken
// meanwhile and waits in the done state until the register frees.
module sprite_sheet_frame_sequencer_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ssfs_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ssfs_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  ssfs_chan_if.sink                            req_i,
  ssfs_chan_if.source                          rsp_o
);
  import ssfs_pkg::*;

  state_e          state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  cfg_t            cfg_q;
  logic [IDX_W-1:0] frame_q, frame_d;
  logic            paused_q, paused_d;
  logic            end_q, end_d;
  logic            ovalid_q, ovalid_d;
  out_item_t       out_q, out_d;
  logic            out_load;
  geom_t           geom;
  acc_ctrl_t       acc_ctrl;
  div_ctrl_t       div_ctrl;
  logic            ge;
  logic [UV_W-1:0] cu, cv, hu, hv;
  logic            in_acc;
  in_item_t        req;

  assign req    = req_i.data;
  assign in_acc = req_i.valid & req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.column_count    <= GRID_W'(1);
      cfg_q.row_count       <= GRID_W'(1);
      cfg_q.row_select      <= '0;
      cfg_q.first_column    <= '0;
      cfg_q.last_column_sel <= '1;
      cfg_q.frame_delay     <= '0;
      cfg_q.play_mode       <= MODE_LOOP;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_COLUMN_COUNT:    cfg_q.column_count    <= cfg_data_i[GRID_W-1:0];
        CFG_ROW_COUNT:       cfg_q.row_count       <= cfg_data_i[GRID_W-1:0];
        CFG_ROW_SELECT:      cfg_q.row_select      <= cfg_data_i[IDX_W-1:0];
        CFG_FIRST_COLUMN:    cfg_q.first_column    <= cfg_data_i[IDX_W-1:0];
        CFG_LAST_COLUMN_SEL: cfg_q.last_column_sel <= signed'(cfg_data_i[GRID_W-1:0]);
        CFG_FRAME_DELAY:     cfg_q.frame_delay     <= cfg_data_i[EL_W-1:0];
        CFG_PLAY_MODE:       cfg_q.play_mode       <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  ssfs_geom u_geom (
    .cfg_i   (cfg_q),
    .frame_i (frame_q),
    .geom_o  (geom)
  );

  ssfs_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (acc_ctrl),
    .delta_i (req.time_delta),
    .delay_i (cfg_q.frame_delay),
    .ge_o    (ge)
  );

  ssfs_div_lane u_div_cu (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (div_ctrl),
    .idx_i (geom.col), .den_i (geom.cols), .quo_o (cu)
  );

  ssfs_div_lane u_div_cv (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (div_ctrl),
    .idx_i (geom.row), .den_i (geom.rows), .quo_o (cv)
  );

  ssfs_div_lane u_div_hu (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (div_ctrl),
    .idx_i ('0), .den_i (geom.cols), .quo_o (hu)
  );

  ssfs_div_lane u_div_hv (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (div_ctrl),
    .idx_i ('0), .den_i (geom.rows), .quo_o (hv)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    frame_d   = frame_q;
    paused_d  = paused_q;
    end_d     = end_q;
    acc_ctrl  = '0;
    div_ctrl  = '0;
    out_load  = 1'b0;
    ovalid_d  = ovalid_q & ~rsp_o.ready;
    req_i.ready = (state_q == ST_IDLE);

    out_d.frame_index  = frame_q;
    out_d.column_index = geom.col;
    out_d.row_index    = geom.row;
    out_d.center_u     = cu;
    out_d.center_v     = cv;
    out_d.half_u       = hu;
    out_d.half_v       = hv;
    out_d.is_paused    = paused_q;
    out_d.reached_end  = end_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_DONE;
          unique case (func_e'(req.func))
            FN_TICK: begin
              if (!paused_q) begin
                acc_ctrl.load = 1'b1;
                cnt_d         = '0;
                state_d       = ST_ACC;
              end
            end
            FN_PLAY: begin
              paused_d = 1'b0;
              end_d    = 1'b0;
            end
            FN_PAUSE:  paused_d = 1'b1;
            FN_RESUME: paused_d = 1'b0;
            FN_INIT: begin
              frame_d        = '0;
              paused_d       = 1'b0;
              acc_ctrl.clear = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_ACC: begin
        acc_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ACC_STEPS - 1)) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (ge) begin
          acc_ctrl.clear = 1'b1;
          if (mode_e'(cfg_q.play_mode) == MODE_LOOP) begin
            frame_d = (frame_q >= geom.span) ? '0 : frame_q + IDX_W'(1);
          end else if (frame_q < geom.span) begin
            frame_d = frame_q + IDX_W'(1);
          end else begin
            paused_d = 1'b1;
            if (mode_e'(cfg_q.play_mode) == MODE_ONCE ||
                mode_e'(cfg_q.play_mode) == MODE_ONCE_HOLD) begin
              end_d = 1'b1;
            end
          end
        end
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        div_ctrl.load = 1'b1;
        cnt_d         = '0;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        div_ctrl.step = 1'b1;
        cnt_d         = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ovalid_q || rsp_o.ready) begin
          out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      frame_q  <= '0;
      paused_q <= 1'b1;
      end_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      frame_q  <= frame_d;
      paused_q <= paused_d;
      end_q    <= end_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid = ovalid_q;
  assign rsp_o.data  = out_q;

endmodule

// File: hdl/ssfs_geom.sv
module ssfs_geom (
  input  ssfs_pkg::cfg_t                      cfg_i,
  input  logic [ssfs_pkg::IDX_W-1:0]          frame_i,
  output ssfs_pkg::geom_t                     geom_o
);
  import ssfs_pkg::*;

  logic [GRID_W-1:0] cols;
  logic [GRID_W-1:0] rows;
  logic [IDX_W-1:0]  cm1;
  logic [IDX_W-1:0]  rm1;
  logic [IDX_W-1:0]  start;
  logic [IDX_W-1:0]  e0;
  logic [IDX_W-1:0]  e1;
  logic [IDX_W-1:0]  stop;
  logic [IDX_W-1:0]  span;
  logic [IDX_W-1:0]  frm;

  always_comb begin
    if (cfg_i.column_count == '0) begin
      cols = GRID_W'(1);
    end else if (cfg_i.column_count > GRID_W'(MAX_GRID)) begin
      cols = GRID_W'(MAX_GRID);
    end else begin
      cols = cfg_i.column_count;
    end
    if (cfg_i.row_count == '0) begin
      rows = GRID_W'(1);
    end else if (cfg_i.row_count > GRID_W'(MAX_GRID)) begin
      rows = GRID_W'(MAX_GRID);
    end else begin
      rows = cfg_i.row_count;
    end
    cm1   = IDX_W'(cols - GRID_W'(1));
    rm1   = IDX_W'(rows - GRID_W'(1));
    start = (cfg_i.first_column > cm1) ? cm1 : cfg_i.first_column;
    e0    = cfg_i.last_column_sel[GRID_W-1] ? cm1 : cfg_i.last_column_sel[IDX_W-1:0];
    e1    = (e0 > cm1) ? cm1 : e0;
    stop  = (e1 < start) ? start : e1;
    span  = stop - start;
    frm   = (frame_i > span) ? span : frame_i;

    geom_o.cols = cols;
    geom_o.rows = rows;
    geom_o.span = span;
    geom_o.col  = start + frm;
    geom_o.row  = (cfg_i.row_select > rm1) ? rm1 : cfg_i.row_select;
  end

endmodule

// File: hdl/ssfs_accum.sv
module ssfs_accum (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssfs_pkg::acc_ctrl_t            ctrl_i,
  input  logic [ssfs_pkg::DELTA_W-1:0]   delta_i,
  input  logic [ssfs_pkg::EL_W-1:0]      delay_i,
  output logic                           ge_o
);
  import ssfs_pkg::*;

  logic [EL_W-1:0]  el_q, el_d;
  logic [EL_W-1:0]  dsr_q, dsr_d;
  logic [EL_W-1:0]  lsr_q, lsr_d;
  logic             cy_q, cy_d;
  logic             bw_q, bw_d;
  logic [DIG_W:0]   sum;
  logic [DIG_W:0]   diff;

  always_comb begin
    sum   = {1'b0, el_q[DIG_W-1:0]} + {1'b0, dsr_q[DIG_W-1:0]} + (DIG_W+1)'(cy_q);
    diff  = {1'b0, sum[DIG_W-1:0]} - {1'b0, lsr_q[DIG_W-1:0]} - (DIG_W+1)'(bw_q);
    el_d  = el_q;
    dsr_d = dsr_q;
    lsr_d = lsr_q;
    cy_d  = cy_q;
    bw_d  = bw_q;
    if (ctrl_i.clear) begin
      el_d = '0;
    end else if (ctrl_i.step) begin
      el_d = {sum[DIG_W-1:0], el_q[EL_W-1:DIG_W]};
    end
    if (ctrl_i.load) begin
      dsr_d = EL_W'(delta_i);
      lsr_d = delay_i;
      cy_d  = 1'b0;
      bw_d  = 1'b0;
    end else if (ctrl_i.step) begin
      dsr_d = dsr_q >> DIG_W;
      lsr_d = lsr_q >> DIG_W;
      cy_d  = sum[DIG_W];
      bw_d  = diff[DIG_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      el_q <= '0;
      cy_q <= 1'b0;
      bw_q <= 1'b0;
    end else begin
      el_q <= el_d;
      cy_q <= cy_d;
      bw_q <= bw_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsr_q <= dsr_d;
    lsr_q <= lsr_d;
  end

  // a carry out means the sum overflowed 32 bits, which always reaches the delay
  assign ge_o = cy_q | ~bw_q;

endmodule

// File: hdl/ssfs_div_lane.sv
module ssfs_div_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ssfs_pkg::div_ctrl_t           ctrl_i,
  input  logic [ssfs_pkg::IDX_W-1:0]    idx_i,
  input  logic [ssfs_pkg::GRID_W-1:0]   den_i,
  output logic [ssfs_pkg::UV_W-1:0]     quo_o
);
  import ssfs_pkg::*;

  // dividend is (2*idx+1) << 15: the top bits seed the remainder
  logic [IDX_W-1:0]  rem_q, rem_d;
  logic [UV_W-1:0]   nsr_q, nsr_d;
  logic [UV_W-1:0]   quo_q, quo_d;
  logic [IDX_W:0]    trial;
  logic              fit;

  always_comb begin
    trial = {rem_q, nsr_q[UV_W-1]};
    fit   = (trial >= den_i);
    rem_d = rem_q;
    nsr_d = nsr_q;
    quo_d = quo_q;
    if (ctrl_i.load) begin
      rem_d = idx_i;
      nsr_d = {1'b1, {(UV_W-1){1'b0}}};
    end else if (ctrl_i.step) begin
      rem_d = fit ? IDX_W'(trial - den_i) : IDX_W'(trial);
      nsr_d = nsr_q << 1;
      quo_d = {quo_q[UV_W-2:0], fit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q <= '0;
    end else begin
      quo_q <= quo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    nsr_q <= nsr_d;
  end

  assign quo_o = quo_q;

endmodule

// File: hdl/ssfs_chk.sv
module ssfs_chk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  ssfs_pkg::out_item_t  out_data_i
);
  import ssfs_pkg::*;

  logic [1:0] pend_q, pend_d;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i & in_ready_i;
  assign out_acc = out_valid_i & out_ready_i;

  always_comb begin
    pend_d = pend_q + 2'(in_acc) - 2'(out_acc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != 2'd0)
    else $error("result without request");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many requests in flight");

endmodule

bind sprite_sheet_frame_sequencer_core ssfs_chk u_ssfs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .out_data_i  (rsp_o.data)
);

// File: verif/testbench.sv
module testbench;
  import ssfs_pkg::*;

  localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] FN_UNUSED_LAST  = 3'd7;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES   = 40;

  typedef struct {
    int unsigned cols;
    int unsigned rows;
    int unsigned first;
    int unsigned span;
    int unsigned col;
    int unsigned row;
  } sheet_geom_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ssfs_chan_if #(.T(in_item_t)) req_if ();
  ssfs_chan_if #(.T(out_item_t)) rsp_if ();

  sprite_sheet_frame_sequencer_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // sheet shadow and animation state
  cfg_t        sheet_cfg;
  logic        paused_q;
  logic        end_q;
  logic [7:0]  frame_q;
  logic [31:0] elapsed_q;
  logic [15:0] center_u_q;
  logic [15:0] center_v_q;
  logic [15:0] half_u_q;
  logic [15:0] half_v_q;

  out_item_t pending_frames[$];
  int error_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int settings_loaded = 0;
  int idle_cycles = 0;
  int rsp_stall = 0;
  bit calm = 1'b0;
  bit req_up = 1'b0;

  function automatic int unsigned clamp_grid(int unsigned n);
    if (n < 1) return 1;
    if (n > MAX_GRID) return MAX_GRID;
    return n;
  endfunction

  function automatic sheet_geom_t sheet_geometry();
    sheet_geom_t g;
    int unsigned last;
    int unsigned f;
    int sel;
    g.cols = clamp_grid(sheet_cfg.column_count);
    g.rows = clamp_grid(sheet_cfg.row_count);
    g.first = sheet_cfg.first_column;
    if (g.first > g.cols - 1) g.first = g.cols - 1;
    sel = $signed(sheet_cfg.last_column_sel);
    if (sel < 0) last = g.cols - 1;
    else last = sel;
    if (last > g.cols - 1) last = g.cols - 1;
    if (last < g.first) last = g.first;
    g.span = last - g.first + 1;
    f = frame_q;
    if (f > g.span - 1) f = g.span - 1;
    g.col = g.first + f;
    g.row = (sheet_cfg.row_select > g.rows - 1) ? g.rows - 1 : sheet_cfg.row_select;
    return g;
  endfunction

  function automatic void advance_clock(logic [15:0] delta);
    sheet_geom_t g;
    logic [63:0] sum;
    int unsigned nxt;
    g = sheet_geometry();
    sum = 64'(elapsed_q) + 64'(delta);
    if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
    elapsed_q = sum[31:0];
    if (elapsed_q >= sheet_cfg.frame_delay) begin
      elapsed_q = '0;
      if (sheet_cfg.play_mode == MODE_LOOP) begin
        nxt = int'(frame_q) + 1;
        if (nxt >= g.span) nxt = 0;
        frame_q = 8'(nxt);
      end else if (frame_q < g.span - 1) begin
        frame_q = frame_q + 8'd1;
      end else begin
        paused_q = 1'b1;
        if (sheet_cfg.play_mode >= MODE_ONCE) end_q = 1'b1;
      end
    end
    g = sheet_geometry();
    half_u_q = 16'(65536 / (2 * g.cols));
    half_v_q = 16'(65536 / (2 * g.rows));
    center_u_q = 16'(((2 * g.col + 1) * 65536) / (2 * g.cols));
    center_v_q = 16'(((2 * g.row + 1) * 65536) / (2 * g.rows));
  endfunction

  function automatic out_item_t step_sheet(in_item_t it);
    out_item_t r;
    sheet_geom_t g;
    case (it.func)
      FN_TICK: if (!paused_q) advance_clock(it.time_delta);
      FN_PLAY: begin
        paused_q = 1'b0;
        end_q = 1'b0;
      end
      FN_PAUSE: paused_q = 1'b1;
      FN_RESUME: paused_q = 1'b0;
      FN_INIT: begin
        frame_q = '0;
        elapsed_q = '0;
        paused_q = 1'b0;
      end
      default: ;
    endcase
    g = sheet_geometry();
    r.frame_index = frame_q;
    r.column_index = 8'(g.col);
    r.row_index = 8'(g.row);
    r.center_u = center_u_q;
    r.center_v = center_v_q;
    r.half_u = half_u_q;
    r.half_v = half_v_q;
    r.is_paused = paused_q;
    r.reached_end = end_q;
    return r;
  endfunction

  function automatic void reset_sheet();
    sheet_cfg.column_count = 9'd1;
    sheet_cfg.row_count = 9'd1;
    sheet_cfg.row_select = '0;
    sheet_cfg.first_column = '0;
    sheet_cfg.last_column_sel = 9'h1FF;
    sheet_cfg.frame_delay = '0;
    sheet_cfg.play_mode = MODE_LOOP;
    paused_q = 1'b1;
    end_q = 1'b0;
    frame_q = '0;
    elapsed_q = '0;
    center_u_q = '0;
    center_v_q = '0;
    half_u_q = '0;
    half_v_q = '0;
  endfunction

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  // result checker and watchdog
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (rsp_if.valid && rsp_if.ready) begin
        got = rsp_if.data;
        results_seen++;
        if (pending_frames.size() == 0) begin
          $display("%0t unexpected result: nothing pending, actual frame %0d column %0d",
                   $time, got.frame_index, got.column_index);
          error_count++;
        end else begin
          want = pending_frames.pop_front();
          check_field("frame_index", want.frame_index, got.frame_index);
          check_field("column_index", want.column_index, got.column_index);
          check_field("row_index", want.row_index, got.row_index);
          check_field("center_u", want.center_u, got.center_u);
          check_field("center_v", want.center_v, got.center_v);
          check_field("half_u", want.half_u, got.half_u);
          check_field("half_v", want.half_v, got.half_v);
          check_field("is_paused", want.is_paused, got.is_paused);
          check_field("reached_end", want.reached_end, got.reached_end);
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t timeout: no transaction for %0d cycles, %0d results pending",
                 $time, idle_cycles, pending_frames.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result backpressure
  always @(negedge clk_i) begin
    if (rsp_stall > 0) begin
      rsp_stall--;
      rsp_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      rsp_stall = $urandom_range(0, 8);
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  task automatic send_item(logic [2:0] func, logic [15:0] delta);
    in_item_t it;
    it.func = func;
    it.time_delta = delta;
    req_if.valid <= 1'b1;
    req_if.data <= it;
    req_up = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    pending_frames.push_back(step_sheet(it));
    items_sent++;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 6) == 0) begin
      req_if.valid <= 1'b0;
      req_up = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    if (req_up) begin
      req_if.valid <= 1'b0;
      req_up = 1'b0;
    end
    while (pending_frames.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    case (idx)
      CFG_COLUMN_COUNT: sheet_cfg.column_count = value[8:0];
      CFG_ROW_COUNT: sheet_cfg.row_count = value[8:0];
      CFG_ROW_SELECT: sheet_cfg.row_select = value[7:0];
      CFG_FIRST_COLUMN: sheet_cfg.first_column = value[7:0];
      CFG_LAST_COLUMN_SEL: sheet_cfg.last_column_sel = value[8:0];
      CFG_FRAME_DELAY: sheet_cfg.frame_delay = value;
      CFG_PLAY_MODE: sheet_cfg.play_mode = value[1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic load_sheet(int cols, int rows, int row_sel, int first, int last,
                            logic [31:0] delay, mode_e mode);
    wait_idle();
    write_reg(CFG_COLUMN_COUNT, 32'(cols));
    write_reg(CFG_ROW_COUNT, 32'(rows));
    write_reg(CFG_ROW_SELECT, 32'(row_sel));
    write_reg(CFG_FIRST_COLUMN, 32'(first));
    write_reg(CFG_LAST_COLUMN_SEL, 32'(last));
    write_reg(CFG_FRAME_DELAY, delay);
    write_reg(CFG_PLAY_MODE, 32'(mode));
    settings_loaded++;
  endtask

  task automatic test_power_on();
    send_item(FN_TICK, 16'd7);
    send_item(FN_UNUSED_FIRST, 16'h5A5A);
    send_item(FN_UNUSED_LAST, 16'hA5A5);
    send_item(FN_RESUME, 16'd0);
    send_item(FN_TICK, 16'd0);
    send_item(FN_PAUSE, 16'd0);
    send_item(FN_PLAY, 16'hFFFF);
  endtask

  task automatic test_play_modes();
    mode_e mode;
    for (int m = 0; m < 4; m++) begin
      mode = mode_e'(m);
      load_sheet(4, 3, 2, 1, 2, 32'd0, mode);
      send_item(FN_INIT, 16'd0);
      send_item(FN_TICK, 16'd1);
      send_item(FN_TICK, 16'd2);
    end
    // hold at end: paused tick, init keeps the end flag, play clears it
    send_item(FN_TICK, 16'd3);
    send_item(FN_INIT, 16'd0);
    send_item(FN_PLAY, 16'd0);
  endtask

  task automatic test_sheet_extremes();
    load_sheet(8, 2, 9, 2, -1, 32'd0, MODE_LOOP);
    send_item(FN_INIT, 16'd0);
    repeat (3) send_item(FN_TICK, 16'd1);
    // shrink the range under the current frame
    wait_idle();
    write_reg(CFG_LAST_COLUMN_SEL, 32'd3);
    send_item(FN_RESUME, 16'd0);
    send_item(FN_TICK, 16'd1);

    load_sheet(256, 256, 255, 255, -1, 32'hFFFF_FFFF, MODE_ONCE_HOLD);
    send_item(FN_INIT, 16'd0);
    send_item(FN_TICK, 16'hFFFF);

    load_sheet(0, 511, 0, 0, 255, 32'd0, MODE_LOOP_HOLD);
    send_item(FN_INIT, 16'd0);
    send_item(FN_TICK, 16'd0);

    load_sheet(10, 1, 0, 7, 3, 32'd0, MODE_LOOP);
    send_item(FN_TICK, 16'd0);
  endtask

  function automatic int pick_grid();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return $urandom_range(257, 511);
      2: return 256;
      3: return $urandom_range(1, 256);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  task automatic test_random_sheets();
    int cols;
    int rows;
    int first;
    int last;
    int pick;
    logic [31:0] delay;
    logic [15:0] delta;
    for (int p = 0; p < 11; p++) begin
      calm = (p >= 9);
      if (p == 5) begin
        // full-width loop: walk every frame and wrap
        load_sheet(256, 4, 1, 0, -1, 32'd0, MODE_LOOP);
        send_item(FN_INIT, 16'd0);
        repeat (300) send_item(FN_TICK, 16'($urandom_range(0, 65535)));
      end else begin
        cols = pick_grid();
        rows = pick_grid();
        first = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 12);
        case ($urandom_range(0, 9))
          0, 1, 2: last = -1;
          3: last = -int'($urandom_range(1, 256));
          4: last = $urandom_range(0, 255);
          default: last = $urandom_range(0, 20);
        endcase
        case ($urandom_range(0, 9))
          0: delay = 32'd0;
          1: delay = 32'hFFFF_FFFF;
          2, 3, 4: delay = $urandom_range(1, 65535);
          default: delay = $urandom_range(65536, 300000);
        endcase
        load_sheet(cols, rows, $urandom_range(0, 255), first, last, delay,
                   mode_e'($urandom_range(0, 3)));
        send_item(FN_PLAY, 16'($urandom_range(0, 65535)));
        repeat (80) begin
          pick = $urandom_range(0, 99);
          case ($urandom_range(0, 9))
            0: delta = 16'd0;
            1: delta = 16'hFFFF;
            default: delta = 16'($urandom_range(0, 65535));
          endcase
          if (pick < 78) send_item(FN_TICK, delta);
          else if (pick < 85) send_item(FN_PLAY, delta);
          else if (pick < 89) send_item(FN_PAUSE, delta);
          else if (pick < 93) send_item(FN_RESUME, delta);
          else if (pick < 97) send_item(FN_INIT, delta);
          else send_item(3'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST)), delta);
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    rsp_if.ready = 1'b0;
    reset_sheet();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_power_on();
    test_play_modes();
    test_sheet_extremes();
    test_random_sheets();

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (pending_frames.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, pending_frames.size());
      error_count++;
    end

    $display("Run covered %0d requests and %0d checked results over %0d sheet settings,",
             items_sent, results_seen, settings_loaded);
    $display("all four play modes, clamped geometry and a full 256-frame loop; %0d errors",
             error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sprite_sheet_frame_sequencer_core.f
hdl/ssfs_pkg.sv
hdl/ssfs_chan_if.sv
hdl/ssfs_geom.sv
hdl/ssfs_accum.sv
hdl/ssfs_div_lane.sv
hdl/sprite_sheet_frame_sequencer_core.sv
hdl/ssfs_chk.sv
verif/testbench.sv
